/* src/lappwr_pkg.sv */
// Shared types and constants of the lap timer with power averaging.
package lappwr_pkg;

    localparam int TIME_W    = 32;
    localparam int SUM_W     = 48;
    localparam int COUNT_W   = 32;
    localparam int POWER_W   = 16;
    localparam int OPCODE_W  = 3;
    localparam int IDX_W     = 5;
    localparam int LAPS_W    = 6;
    localparam int MODE_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 3'd0,
        OP_PAUSE  = 3'd1,
        OP_RESUME = 3'd2,
        OP_STOP   = 3'd3,
        OP_LAP    = 3'd4,
        OP_SAMPLE = 3'd5,
        OP_STATUS = 3'd6,
        OP_READ   = 3'd7
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSED  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REC_GO,
        ST_REC_WAIT,
        ST_TOT_GO,
        ST_TOT_WAIT,
        ST_LAP_GO,
        ST_LAP_WAIT,
        ST_DONE
    } fsm_t;

    // One stored lap record as it sits in the lap table memory.
    typedef struct packed {
        logic [TIME_W-1:0]  duration;
        logic [SUM_W-1:0]   power_sum;
        logic [COUNT_W-1:0] samples;
        logic [POWER_W-1:0] avg_power;
    } lap_rec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* src/lap_timer_with_power_average.sv */
// Top level of the lap timer with power averaging: sequencer, state and lap table.
// A stopwatch with stopped, running and paused states driven by timestamped requests.
// One request is worked at a time. The shared 48-step divider forms, on a recorded lap,
// the stored lap average first, then the workout average and the lap average, one
// after another. Lap records live in a LAP_SLOTS-entry RAM with registered read;
// a record is reported only below the lap count, so the table needs no clearing after
// reset. The next request is taken while the previous result still waits at the output.
module lap_timer_with_power_average #(
    parameter int LAP_SLOTS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [lappwr_pkg::OPCODE_W-1:0]       opcode,
    input  logic [lappwr_pkg::TIME_W-1:0]         now_ms,
    input  logic [lappwr_pkg::POWER_W-1:0]        power_sample,
    input  logic [lappwr_pkg::IDX_W-1:0]          lap_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lappwr_pkg::MODE_W-1:0]         run_state,
    output logic [lappwr_pkg::TIME_W-1:0]         elapsed_ms,
    output logic [lappwr_pkg::TIME_W-1:0]         lap_ms,
    output logic [lappwr_pkg::POWER_W-1:0]        total_avg_power,
    output logic [lappwr_pkg::POWER_W-1:0]        lap_avg_power,
    output logic [lappwr_pkg::LAPS_W-1:0]         laps_done,
    output logic                                  record_valid,
    output logic [lappwr_pkg::TIME_W-1:0]         record_duration_ms,
    output logic [lappwr_pkg::SUM_W-1:0]          record_power_sum,
    output logic [lappwr_pkg::COUNT_W-1:0]        record_samples,
    output logic [lappwr_pkg::POWER_W-1:0]        record_avg_power
);

    localparam int CW   = $clog2(LAP_SLOTS + 1);
    localparam int AW   = (LAP_SLOTS > 1) ? $clog2(LAP_SLOTS) : 1;
    localparam int CMPW = (CW > lappwr_pkg::IDX_W) ? CW : lappwr_pkg::IDX_W;
    localparam int TW   = lappwr_pkg::TIME_W;
    localparam int SW   = lappwr_pkg::SUM_W;
    localparam int NW   = lappwr_pkg::COUNT_W;
    localparam int PW   = lappwr_pkg::POWER_W;

    lappwr_pkg::fsm_t  state_reg, state_next;
    lappwr_pkg::mode_t mode_reg, mode_next;

    logic [TW-1:0] ws_reg, ws_next;
    logic [TW-1:0] ls_reg, ls_next;
    logic [TW-1:0] pm_reg, pm_next;
    logic [TW-1:0] wpt_reg, wpt_next;
    logic [TW-1:0] lpt_reg, lpt_next;
    logic [SW-1:0] wsum_reg, wsum_next;
    logic [NW-1:0] wcnt_reg, wcnt_next;
    logic [SW-1:0] lsum_reg, lsum_next;
    logic [NW-1:0] lcnt_reg, lcnt_next;
    logic [CW-1:0] laps_reg, laps_next;

    // request held while it is worked
    lappwr_pkg::op_t           op_reg, op_next;
    logic [TW-1:0]             now_reg, now_next;
    logic [PW-1:0]             pw_reg, pw_next;
    logic [lappwr_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [PW-1:0]             tavg_reg, tavg_next;
    logic [PW-1:0]             lavg_reg, lavg_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [lappwr_pkg::MODE_W-1:0] o_state_reg, o_state_next;
    logic [TW-1:0]             o_elapsed_reg, o_elapsed_next;
    logic [TW-1:0]             o_lap_reg, o_lap_next;
    logic [PW-1:0]             o_tavg_reg, o_tavg_next;
    logic [PW-1:0]             o_lavg_reg, o_lavg_next;
    logic [lappwr_pkg::LAPS_W-1:0] o_laps_reg, o_laps_next;
    logic                      o_rv_reg, o_rv_next;
    lappwr_pkg::lap_rec_t      o_rec_reg, o_rec_next;

    logic                      div_start;
    logic [SW-1:0]             div_dividend;
    logic [NW-1:0]             div_divisor;
    lappwr_pkg::div_stat_t     div_stat;
    logic [PW-1:0]             div_quot;

    logic                      ram_we;
    logic                      ram_re;
    lappwr_pkg::lap_rec_t      ram_wdata;
    lappwr_pkg::lap_rec_t      ram_rdata;

    logic [TW-1:0]             t_now;
    logic [TW-1:0]             pause_gap;
    logic                      lap_ok;
    logic                      rec_hit;

    lappwr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    lappwr_ram #(
        .WIDTH ($bits(lappwr_pkg::lap_rec_t)),
        .DEPTH (LAP_SLOTS)
    ) u_lap_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (laps_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(idx_reg)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ws_next        = ws_reg;
        ls_next        = ls_reg;
        pm_next        = pm_reg;
        wpt_next       = wpt_reg;
        lpt_next       = lpt_reg;
        wsum_next      = wsum_reg;
        wcnt_next      = wcnt_reg;
        lsum_next      = lsum_reg;
        lcnt_next      = lcnt_reg;
        laps_next      = laps_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        pw_next        = pw_reg;
        idx_next       = idx_reg;
        tavg_next      = tavg_reg;
        lavg_next      = lavg_reg;
        out_valid_next = out_valid_reg;
        o_state_next   = o_state_reg;
        o_elapsed_next = o_elapsed_reg;
        o_lap_next     = o_lap_reg;
        o_tavg_next    = o_tavg_reg;
        o_lavg_next    = o_lavg_reg;
        o_laps_next    = o_laps_reg;
        o_rv_next      = o_rv_reg;
        o_rec_next     = o_rec_reg;
        in_ready       = 1'b0;
        div_start      = 1'b0;
        div_dividend   = lsum_reg;
        div_divisor    = lcnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        ram_wdata.duration  = (now_reg - ls_reg) - lpt_reg;
        ram_wdata.power_sum = lsum_reg;
        ram_wdata.samples   = lcnt_reg;
        ram_wdata.avg_power = div_quot;

        t_now     = (mode_reg == lappwr_pkg::MODE_PAUSED) ? pm_reg : now_reg;
        pause_gap = now_reg - pm_reg;
        lap_ok    = (mode_reg == lappwr_pkg::MODE_RUNNING) && (laps_reg < CW'(LAP_SLOTS));
        rec_hit   = (op_reg == lappwr_pkg::OP_READ) && (CMPW'(idx_reg) < CMPW'(laps_reg));

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lappwr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = lappwr_pkg::op_t'(opcode);
                    now_next   = now_ms;
                    pw_next    = power_sample;
                    idx_next   = lap_index;
                    state_next = lappwr_pkg::ST_EXEC;
                end
            end
            lappwr_pkg::ST_EXEC:
            begin
                state_next = lappwr_pkg::ST_TOT_GO;
                unique case (op_reg)
                    lappwr_pkg::OP_START:
                    begin
                        if (mode_reg == lappwr_pkg::MODE_STOPPED)
                        begin
                            ws_next   = now_reg;
                            ls_next   = now_reg;
                            wpt_next  = '0;
                            lpt_next  = '0;
                            wsum_next = '0;
                            wcnt_next = '0;
                            lsum_next = '0;
                            lcnt_next = '0;
                            laps_next = '0;
                            mode_next = lappwr_pkg::MODE_RUNNING;
                        end
                    end
                    lappwr_pkg::OP_PAUSE:
                    begin
                        if (mode_reg == lappwr_pkg::MODE_RUNNING)
                        begin
                            pm_next   = now_reg;
                            mode_next = lappwr_pkg::MODE_PAUSED;
                        end
                    end
                    lappwr_pkg::OP_RESUME:
                    begin
                        if (mode_reg == lappwr_pkg::MODE_PAUSED)
                        begin
                            wpt_next  = wpt_reg + pause_gap;
                            lpt_next  = lpt_reg + pause_gap;
                            mode_next = lappwr_pkg::MODE_RUNNING;
                        end
                    end
                    lappwr_pkg::OP_STOP:
                    begin
                        mode_next = lappwr_pkg::MODE_STOPPED;
                    end
                    lappwr_pkg::OP_LAP:
                    begin
                        // average the closing lap before its sums are cleared
                        if (lap_ok)
                        begin
                            state_next = lappwr_pkg::ST_REC_GO;
                        end
                    end
                    lappwr_pkg::OP_SAMPLE:
                    begin
                        if (mode_reg == lappwr_pkg::MODE_RUNNING)
                        begin
                            if (wcnt_reg != '1)
                            begin
                                wsum_next = wsum_reg + SW'(pw_reg);
                                wcnt_next = wcnt_reg + 1'b1;
                            end
                            if (lcnt_reg != '1)
                            begin
                                lsum_next = lsum_reg + SW'(pw_reg);
                                lcnt_next = lcnt_reg + 1'b1;
                            end
                        end
                    end
                    lappwr_pkg::OP_STATUS:
                    begin
                    end
                    lappwr_pkg::OP_READ:
                    begin
                        ram_re = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            lappwr_pkg::ST_REC_GO:
            begin
                div_start  = 1'b1;
                state_next = lappwr_pkg::ST_REC_WAIT;
            end
            lappwr_pkg::ST_REC_WAIT:
            begin
                if (div_stat.done)
                begin
                    ram_we     = 1'b1;
                    laps_next  = laps_reg + 1'b1;
                    ls_next    = now_reg;
                    lpt_next   = '0;
                    lsum_next  = '0;
                    lcnt_next  = '0;
                    state_next = lappwr_pkg::ST_TOT_GO;
                end
            end
            lappwr_pkg::ST_TOT_GO:
            begin
                div_start    = 1'b1;
                div_dividend = wsum_reg;
                div_divisor  = wcnt_reg;
                state_next   = lappwr_pkg::ST_TOT_WAIT;
            end
            lappwr_pkg::ST_TOT_WAIT:
            begin
                if (div_stat.done)
                begin
                    tavg_next  = div_quot;
                    state_next = lappwr_pkg::ST_LAP_GO;
                end
            end
            lappwr_pkg::ST_LAP_GO:
            begin
                div_start  = 1'b1;
                state_next = lappwr_pkg::ST_LAP_WAIT;
            end
            lappwr_pkg::ST_LAP_WAIT:
            begin
                if (div_stat.done)
                begin
                    lavg_next  = div_quot;
                    state_next = lappwr_pkg::ST_DONE;
                end
            end
            lappwr_pkg::ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_state_next   = mode_reg;
                    if (mode_reg == lappwr_pkg::MODE_STOPPED)
                    begin
                        o_elapsed_next = '0;
                        o_lap_next     = '0;
                    end
                    else
                    begin
                        o_elapsed_next = (t_now - ws_reg) - wpt_reg;
                        o_lap_next     = (t_now - ls_reg) - lpt_reg;
                    end
                    o_tavg_next = tavg_reg;
                    o_lavg_next = lavg_reg;
                    o_laps_next = lappwr_pkg::LAPS_W'(laps_reg);
                    o_rv_next   = rec_hit;
                    o_rec_next  = rec_hit ? ram_rdata : '0;
                    state_next  = lappwr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lappwr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lappwr_pkg::ST_IDLE;
            mode_reg      <= lappwr_pkg::MODE_STOPPED;
            ws_reg        <= '0;
            ls_reg        <= '0;
            pm_reg        <= '0;
            wpt_reg       <= '0;
            lpt_reg       <= '0;
            wsum_reg      <= '0;
            wcnt_reg      <= '0;
            lsum_reg      <= '0;
            lcnt_reg      <= '0;
            laps_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ws_reg        <= ws_next;
            ls_reg        <= ls_next;
            pm_reg        <= pm_next;
            wpt_reg       <= wpt_next;
            lpt_reg       <= lpt_next;
            wsum_reg      <= wsum_next;
            wcnt_reg      <= wcnt_next;
            lsum_reg      <= lsum_next;
            lcnt_reg      <= lcnt_next;
            laps_reg      <= laps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        now_reg       <= now_next;
        pw_reg        <= pw_next;
        idx_reg       <= idx_next;
        tavg_reg      <= tavg_next;
        lavg_reg      <= lavg_next;
        o_state_reg   <= o_state_next;
        o_elapsed_reg <= o_elapsed_next;
        o_lap_reg     <= o_lap_next;
        o_tavg_reg    <= o_tavg_next;
        o_lavg_reg    <= o_lavg_next;
        o_laps_reg    <= o_laps_next;
        o_rv_reg      <= o_rv_next;
        o_rec_reg     <= o_rec_next;
    end

    assign out_valid          = out_valid_reg;
    assign run_state          = o_state_reg;
    assign elapsed_ms         = o_elapsed_reg;
    assign lap_ms             = o_lap_reg;
    assign total_avg_power    = o_tavg_reg;
    assign lap_avg_power      = o_lavg_reg;
    assign laps_done          = o_laps_reg;
    assign record_valid       = o_rv_reg;
    assign record_duration_ms = o_rec_reg.duration;
    assign record_power_sum   = o_rec_reg.power_sum;
    assign record_samples     = o_rec_reg.samples;
    assign record_avg_power   = o_rec_reg.avg_power;

`ifndef SYNTHESIS
    a_laps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        laps_reg <= CW'(LAP_SLOTS))
        else $error("lap count beyond table size");

    a_write_running: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (mode_reg == lappwr_pkg::MODE_RUNNING) && (laps_reg < CW'(LAP_SLOTS)))
        else $error("lap record written while not running or table full");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == lappwr_pkg::ST_EXEC))
        else $error("accepted request not taken into execution");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lappwr_pkg::ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (run_state == lappwr_pkg::MODE_STOPPED))
            |-> (elapsed_ms == '0) && (lap_ms == '0))
        else $error("nonzero times reported while stopped");
`endif

endmodule

/* src/lappwr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lappwr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lappwr_div.sv */
// Restoring divider, one quotient bit per cycle, low quotient bits returned.
module lappwr_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lappwr_pkg::SUM_W-1:0]    dividend,
    input  logic [lappwr_pkg::COUNT_W-1:0]  divisor,
    output lappwr_pkg::div_stat_t           stat,
    output logic [lappwr_pkg::POWER_W-1:0]  quotient
);

    localparam int DVD_W = lappwr_pkg::SUM_W;
    localparam int DVS_W = lappwr_pkg::COUNT_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DVD_W - 1);
            if (divisor == '0)
            begin
                // no samples: average reads as zero
                quo_next  = '0;
                done_next = 1'b1;
            end
            else
            begin
                quo_next  = dividend;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg[lappwr_pkg::POWER_W-1:0];

endmodule
